// ----- rtl/core/chained_hash_table_unit_defines.svh -----
// Assertion macros for the chained hash table.
`ifndef CHAINED_HASH_TABLE_UNIT_DEFINES_SVH
`define CHAINED_HASH_TABLE_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge out of reset.
`define CHT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication checked out of reset.
`define CHT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/cht_pkg.sv -----
package cht_pkg;

    localparam logic [0:0] KIND_INSERT = 1'b0;
    localparam logic [0:0] KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_POOL_FULL = 2'd3;

    localparam int KEY_W = 31;
    localparam int BKT_W = 6;
    localparam int CNT_W = 7;

    localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

    typedef struct packed {
        logic [0:0]       kind;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [BKT_W-1:0] bucket;
    } t_out_word;

    // front to back: classified word with its bucket
    typedef struct packed {
        logic [0:0]       kind;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } t_cmd_word;

endpackage

// ----- rtl/core/cht_front.sv -----
module cht_front import cht_pkg::*; #(
    parameter int BUCKETS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_bucket_count,
    input  logic             i_push,
    input  t_in_word         i_word,
    output logic             o_full,
    output logic             o_cmd_valid,
    output t_cmd_word        o_cmd,
    input  logic             i_cmd_take
);
    // restoring division remainder, one key bit per cycle
    localparam int CW = $clog2(BUCKETS + 1);
    localparam int SW = $clog2(KEY_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [SW-1:0]    r_step, n_step;
    logic [KEY_W-1:0] r_key;
    logic [0:0]       r_kind;
    logic [CW:0]      r_rem, n_rem;
    logic [CW-1:0]    r_div;
    logic [CW-1:0]    w_div;
    logic [CW:0]      w_sh;

    always_comb begin
        if (i_bucket_count == '0) begin
            w_div = CW'(1);
        end else if (32'(i_bucket_count) > BUCKETS) begin
            w_div = CW'(BUCKETS);
        end else begin
            w_div = CW'(i_bucket_count);
        end
    end

    assign o_full = r_busy | r_done;
    assign w_sh = {r_rem[CW-1:0], r_key[KEY_W-1-32'(r_step)]};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_step = r_step;
        n_rem = r_rem;
        if (i_push && !o_full) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem = '0;
        end else if (r_busy) begin
            n_rem = (w_sh >= {1'b0, r_div}) ? w_sh - {1'b0, r_div} : w_sh;
            n_step = r_step + SW'(1);
            if (32'(r_step) == KEY_W - 1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (r_done && i_cmd_take) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        if (i_push && !o_full) begin
            r_key <= i_word.key;
            r_kind <= i_word.kind;
            r_div <= w_div;
        end
    end

    assign o_cmd_valid = r_done;
    assign o_cmd.kind = r_kind;
    assign o_cmd.key = r_key;
    assign o_cmd.bucket = BKT_W'(r_rem);
endmodule

// ----- rtl/core/cht_back.sv -----
`include "chained_hash_table_unit_defines.svh"
module cht_back import cht_pkg::*; #(
    parameter int BUCKETS = 64,
    parameter int POOL    = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd_word i_cmd,
    output logic      o_cmd_take,
    output logic      o_res_valid,
    output t_out_word o_res,
    input  logic      i_res_take
);
    localparam int PW = $clog2(POOL + 1);
    localparam int AW = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [PW-1:0] NIL = PW'(POOL);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [KEY_W-1:0] m_keys [POOL];
    logic [PW-1:0]    m_links [POOL];
    logic [PW-1:0]    m_heads [BUCKETS];

    logic [2:0]       r_st;
    logic [HW-1:0]    r_clr;
    logic [PW-1:0]    r_fresh, r_free, r_cur, r_prev, r_head;
    logic [PW:0]      r_steps;
    logic [KEY_W-1:0] r_rkey;
    logic [PW-1:0]    r_rlink;
    t_cmd_word        r_cmd;
    t_out_word        r_res;
    logic             r_res_valid;

    assign o_cmd_take = (r_st == S_IDLE) && !r_res_valid && i_cmd_valid;
    assign o_res_valid = r_res_valid;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_fresh <= '0;
            r_free <= NIL;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_take) r_res_valid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    m_heads[r_clr] <= NIL;
                    r_clr <= r_clr + HW'(1);
                    if (32'(r_clr) == BUCKETS - 1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        r_head <= m_heads[HW'(i_cmd.bucket)];
                        r_st <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_res.bucket <= r_cmd.bucket;
                    if (r_cmd.kind == KIND_INSERT) begin
                        if (r_free != NIL) begin
                            r_cur <= r_free;
                            r_rlink <= m_links[AW'(r_free)];
                            r_st <= S_FREE;
                        end else if (r_fresh != NIL) begin
                            m_keys[AW'(r_fresh)] <= r_cmd.key;
                            m_links[AW'(r_fresh)] <= r_head;
                            m_heads[HW'(r_cmd.bucket)] <= r_fresh;
                            r_fresh <= r_fresh + PW'(1);
                            r_res.status <= ST_INSERTED;
                            r_st <= S_OUT;
                        end else begin
                            r_res.status <= ST_POOL_FULL;
                            r_st <= S_OUT;
                        end
                    end else begin
                        r_cur <= r_head;
                        r_prev <= NIL;
                        r_steps <= '0;
                        r_st <= S_RD;
                    end
                end
                S_FREE: begin
                    r_free <= r_rlink;
                    m_keys[AW'(r_cur)] <= r_cmd.key;
                    m_links[AW'(r_cur)] <= r_head;
                    m_heads[HW'(r_cmd.bucket)] <= r_cur;
                    r_res.status <= ST_INSERTED;
                    r_st <= S_OUT;
                end
                S_RD: begin
                    if (r_cur == NIL || 32'(r_steps) >= POOL) begin
                        r_res.status <= ST_NOT_FOUND;
                        r_st <= S_OUT;
                    end else begin
                        r_rkey <= m_keys[AW'(r_cur)];
                        r_rlink <= m_links[AW'(r_cur)];
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_rkey == r_cmd.key) begin
                        if (r_prev == NIL) m_heads[HW'(r_cmd.bucket)] <= r_rlink;
                        else m_links[AW'(r_prev)] <= r_rlink;
                        r_res.status <= ST_REMOVED;
                        r_head <= r_cur;
                        r_st <= S_OUT;
                        r_steps <= '1;
                    end else begin
                        r_prev <= r_cur;
                        r_cur <= r_rlink;
                        r_steps <= r_steps + (PW+1)'(1);
                        r_st <= S_RD;
                    end
                end
                S_OUT: begin
                    if (r_res.status == ST_REMOVED && r_steps == '1) begin
                        // return the node to the free list
                        m_links[AW'(r_head)] <= r_free;
                        r_free <= r_head;
                        r_steps <= '0;
                    end else if (!r_res_valid) begin
                        r_res_valid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `CHT_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_cmd_take, r_st == S_IDLE)
    `CHT_ASSERT_IMP(a_fresh_bound, i_clk, i_rst_n, 1'b1, 32'(r_fresh) <= POOL)
    `CHT_ASSERT_NXT(a_take_head, i_clk, i_rst_n, o_cmd_take, r_st == S_HEAD)
endmodule

// ----- rtl/core/chained_hash_table_unit.sv -----
// Chained hash table: each word inserts or removes a 31-bit key in bucket
// key mod bucket_count (0 acts as 1, capped at BUCKETS). The front computes
// the remainder one key bit per cycle; the back then runs the chain, an insert
// reusing a freed node first and a remove walking node by node. Front and back
// overlap through a one-word buffer. After reset the back clears the BUCKETS
// heads, one per cycle, before taking work. Pool exhaustion gives status 3.
`include "chained_hash_table_unit_defines.svh"
module chained_hash_table_unit import cht_pkg::*; #(
    parameter int BUCKETS = 64,
    parameter int POOL    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  t_in_word    i_word,
    output logic        empty,
    input  logic        pop,
    output t_out_word   o_word
);
    logic [CNT_W-1:0] r_bucket_count;
    logic             w_cmd_valid, w_cmd_take, w_res_valid;
    t_cmd_word        w_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BUCKET_COUNT) ? {25'd0, r_bucket_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CNT_W'(64);
        end else if (psel && penable && pwrite && paddr == REG_BUCKET_COUNT) begin
            r_bucket_count <= pwdata[CNT_W-1:0];
        end
    end

    cht_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bucket_count(r_bucket_count),
        .i_push(push), .i_word(i_word), .o_full(full),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    cht_back #(.BUCKETS(BUCKETS), .POOL(POOL)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .o_res_valid(w_res_valid), .o_res(o_word), .i_res_take(pop)
    );

    assign empty = !w_res_valid;

    `CHT_ASSERT_IMP(a_take_valid, i_clk, i_rst_n, w_cmd_take, w_cmd_valid)
    `CHT_ASSERT_NXT(a_pop_empty, i_clk, i_rst_n, pop && !empty && full, 1'b1)
    `CHT_ASSERT_IMP(a_pready, i_clk, i_rst_n, psel, pready)
endmodule

// ----- tb/chained_hash_table_checker.sv -----
`timescale 1ns / 100ps

module chained_hash_table_checker import cht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [0:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_word    i_word,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_out_word   i_result,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NUM_BUCKETS = 64;
    localparam int NUM_NODES   = 256;
    localparam int NIL         = NUM_NODES;

    int         chain_head [NUM_BUCKETS];
    logic [30:0] slot_key  [NUM_NODES];
    int         slot_next  [NUM_NODES];
    int         fresh_used;
    int         free_top;
    logic [6:0] span_reg;
    t_out_word  expected_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_out_word predict_lookup(input logic [0:0] kind, input logic [30:0] key);
        int        span;
        int        b;
        int        node;
        int        prev;
        int        cur;
        int        steps;
        t_out_word r;
        span = (span_reg == 0) ? 1 : ((span_reg > NUM_BUCKETS) ? NUM_BUCKETS : span_reg);
        b = int'(key % span);
        r.bucket = b[5:0];
        if (kind == KIND_INSERT) begin
            if (free_top != NIL) begin
                node = free_top;
                free_top = slot_next[node];
            end else if (fresh_used < NUM_NODES) begin
                node = fresh_used;
                fresh_used++;
            end else begin
                node = NIL;
            end
            if (node == NIL) begin
                r.status = ST_POOL_FULL;
            end else begin
                slot_key[node]  = key;
                slot_next[node] = chain_head[b];
                chain_head[b]   = node;
                r.status = ST_INSERTED;
            end
        end else begin
            r.status = ST_NOT_FOUND;
            prev  = NIL;
            cur   = chain_head[b];
            steps = 0;
            while (cur != NIL && steps < NUM_NODES) begin
                if (slot_key[cur] == key) begin
                    if (prev == NIL) chain_head[b] = slot_next[cur];
                    else slot_next[prev] = slot_next[cur];
                    slot_next[cur] = free_top;
                    free_top = cur;
                    r.status = ST_REMOVED;
                    break;
                end
                prev = cur;
                cur  = slot_next[cur];
                steps++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUCKETS; i++) chain_head[i] = NIL;
            fresh_used = 0;
            free_top   = NIL;
            span_reg   = 7'd64;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_BUCKET_COUNT)
                span_reg = i_pwdata[6:0];
            if (i_push && !i_full)
                expected_q.push_back(predict_lookup(i_word.kind, i_word.key));
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word: status %0d bucket %0d",
                                 i_result.status, i_result.bucket);
                end else begin
                    want = expected_q.pop_front();
                    if (want.status !== i_result.status || want.bucket !== i_result.bucket) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result mismatch: exp status %0d bucket %0d, got %0d %0d",
                                     want.status, want.bucket,
                                     i_result.status, i_result.bucket);
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- tb/chained_hash_table_unit_test.sv -----
`timescale 1ns / 100ps

module chained_hash_table_unit_test import cht_pkg::*;;

    localparam int IDLE_LIMIT = 4000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [0:0]  paddr   = REG_BUCKET_COUNT;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    logic        full;
    t_in_word    i_word  = '0;
    logic        empty;
    logic        pop     = 1'b0;
    t_out_word   o_word;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          pop_stall   = 0;
    bit          pop_steady  = 1'b0;
    int          words_sent  = 0;
    int          span_writes = 0;
    logic [30:0] live_keys [$];

    always #4 i_clk = ~i_clk;

    chained_hash_table_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .i_word(i_word),
        .empty(empty), .pop(pop), .o_word(o_word)
    );

    chained_hash_table_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .i_push(push), .i_full(full), .i_word(i_word),
        .i_empty(empty), .i_pop(pop), .i_result(o_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [30:0] pick_key();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 150));
            1: return r[30:0];
            2: return 31'($urandom_range(0, 20) * 64);
            default: return 31'($urandom_range(0, 4000));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
        end else begin
            pop <= 1'b1;
            if (!pop_steady) pop_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic [0:0] kind, input logic [30:0] key);
        int  gap;
        bit  ok;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_word.kind <= kind;
        i_word.key  <= key;
        do begin
            @(negedge i_clk);
            ok = !full;
            @(posedge i_clk);
        end while (!ok);
        words_sent++;
        if (kind == KIND_INSERT) live_keys.push_back(key);
    endtask

    task automatic remove_live();
        int idx;
        logic [30:0] k;
        if (live_keys.size() == 0) begin
            send_word(KIND_REMOVE, pick_key());
        end else begin
            idx = $urandom_range(0, live_keys.size() - 1);
            k = live_keys[idx];
            live_keys.delete(idx);
            send_word(KIND_REMOVE, k);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_span(input logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_BUCKET_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        span_writes++;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, head/middle unlinks
        send_word(KIND_INSERT, 31'd0);
        send_word(KIND_INSERT, 31'h7FFF_FFFF);
        send_word(KIND_REMOVE, 31'h7FFF_FFFF);
        send_word(KIND_REMOVE, 31'h7FFF_FFFF);
        send_word(KIND_REMOVE, 31'd12345);
        send_word(KIND_INSERT, 31'd5);
        send_word(KIND_INSERT, 31'd5);
        send_word(KIND_REMOVE, 31'd5);
        send_word(KIND_REMOVE, 31'd5);
        send_word(KIND_REMOVE, 31'd5);
        send_word(KIND_INSERT, 31'd64);
        send_word(KIND_INSERT, 31'd128);
        send_word(KIND_REMOVE, 31'd64);
        send_word(KIND_REMOVE, 31'd128);
        send_word(KIND_REMOVE, 31'd0);
        send_word(KIND_INSERT, 31'h5555_5555);
        send_word(KIND_INSERT, 31'h2AAA_AAAA);
        send_word(KIND_REMOVE, 31'h2AAA_AAAA);
        live_keys.delete();
        live_keys.push_back(31'h5555_5555);

        // zero count acts as one bucket, oversize saturates
        write_span(32'd0);
        for (int i = 0; i < 6; i++) send_word(KIND_INSERT, pick_key());
        remove_live();
        send_word(KIND_REMOVE, 31'h5555_5555);
        write_span(32'd127);
        for (int i = 0; i < 4; i++) remove_live();

        // exhaust the pool, then remove keys until 100 live keys remain tracked
        write_span(32'd7);
        pop_steady = 1'b1;
        for (int i = 0; i < 270; i++) send_word(KIND_INSERT, 31'($urandom_range(0, 500)));
        pop_steady = 1'b0;
        while (live_keys.size() > 100) remove_live();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: write_span(32'd1);
                1: write_span(32'd64);
                2: write_span(32'd63);
                default: write_span(32'($urandom_range(1, 64)));
            endcase
            pop_steady = (phase == 3);
            for (int i = 0; i < 85; i++) begin
                if ($urandom_range(0, 99) < 52) send_word(KIND_INSERT, pick_key());
                else if ($urandom_range(0, 9) < 8) remove_live();
                else send_word(KIND_REMOVE, pick_key());
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d words driven across %0d bucket-count writes,", words_sent, span_writes);
        $display("including pool exhaustion, duplicate keys and shared chains");
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
